// ----- rtl/satl_pkg.sv -----
// shared types and constants of the set-associative tag lookup
// no dependencies
package satl_pkg;

	localparam int ADDR_W    = 32;
	localparam int LFSR_W    = 16;
	localparam int WAY_OUT_W = 2;

	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
	localparam logic [LFSR_W-1:0] LFSR_ONE  = 16'h0001;

	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_INVAL = 1'b1;

	typedef struct packed {
		logic hit;
		logic filled;
		logic evicted;
	} lookup_t;

endpackage

// ----- rtl/satl_way_sel.sv -----
// way compare and replacement choice for one set row
// depends on satl_pkg
module satl_way_sel #(
	parameter int WAYS  = 4,
	parameter int TAG_W = 26,
	parameter int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
	input  logic [WAYS-1:0]            valid_row,
	input  logic [WAYS-1:0][TAG_W-1:0] tag_row,
	input  logic [TAG_W-1:0]           line,
	input  logic [WAY_W-1:0]           victim,
	output satl_pkg::lookup_t          flags,
	output logic [WAY_W-1:0]           sel_way
);
	import satl_pkg::*;

	logic [WAYS-1:0]  match;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] free_way;
	logic             all_valid;

	// scan from the top so the lowest way wins
	always_comb begin
		hit_way  = '0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			match[w] = valid_row[w] && (tag_row[w] == line);
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (!valid_row[w]) begin
				free_way = WAY_W'(w);
			end
		end
	end

	assign all_valid     = &valid_row;
	assign flags.hit     = |match;
	assign flags.filled  = ~(|match);
	assign flags.evicted = ~(|match) & all_valid;

	always_comb begin
		if (|match) begin
			sel_way = hit_way;
		end else if (all_valid) begin
			sel_way = victim;
		end else begin
			sel_way = free_way;
		end
	end

endmodule

// ----- rtl/set_assoc_cache_tag_lookup.sv -----
// top level of the set-associative cache tag lookup with random replacement
// depends on satl_pkg and satl_way_sel
//
// Takes one access item per cycle while in_stall is low and returns one result per item: s1
// registers the line address and its quotient by SETS, s2 holds the tag row read from the tag
// memory, and the output register holds hit, way, filled and evicted.
// The rate is set by the read-modify-write of one set row per cycle in s2; a forward path covers
// a back-to-back access to the set just written. Valid bits sit in flip-flops cleared by reset
// and by an invalidate item all at once, so there is no clearing pass. Writing the seed loads
// the replacement LFSR at once (zero loads as one).
module set_assoc_cache_tag_lookup #(
	parameter int LINE_BYTES = 64,
	parameter int SETS       = 64,
	parameter int WAYS       = 4,
	parameter int ADDR_BITS  = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [satl_pkg::LFSR_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            mode,
	input  logic [satl_pkg::ADDR_W-1:0]     address,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit,
	output logic [satl_pkg::WAY_OUT_W-1:0]  way,
	output logic                            filled,
	output logic                            evicted
);
	import satl_pkg::*;

	localparam int EA    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int SHIFT = $clog2(LINE_BYTES + 1) - 1;
	localparam int LA    = EA - SHIFT;
	localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;

	// set = line mod SETS through a reciprocal that is exact for every LA-bit line
	localparam int SL = (SETS > 1) ? $clog2(SETS) : 0;
	localparam int SK = LA + SL;
	localparam int PW = SK + LA + 1;
	localparam longint unsigned SRECIP = ((64'd1 << SK) + 64'(SETS) - 64'd1) / 64'(SETS);
	localparam logic [LA-1:0] SETS_T = LA'(SETS);

	// victim = lfsr mod WAYS, same scheme on 16 bits
	localparam int VL  = (WAYS > 1) ? $clog2(WAYS) : 0;
	localparam int VK  = LFSR_W + VL;
	localparam int VPW = VK + LFSR_W + 1;
	localparam longint unsigned VRECIP = ((64'd1 << VK) + 64'(WAYS) - 64'd1) / 64'(WAYS);
	localparam logic [LFSR_W-1:0] WAYS_T = LFSR_W'(WAYS);

	// handshake
	logic accept;
	logic v_s1;
	logic v_s2;
	logic out_en;
	logic s1_move;
	logic commit;

	// stage registers
	logic          mode_s1;
	logic [LA-1:0] line_s1;
	logic [LA-1:0] q_s1;
	logic          mode_s2;
	logic [LA-1:0] line_s2;
	logic [SW-1:0] set_s2;

	logic [WAYS-1:0][LA-1:0] tag_rd_s2;
	logic                    byp_s2;
	logic [WW-1:0]           byp_way_s2;
	logic [LA-1:0]           byp_tag_s2;

	logic [WAYS-1:0][LA-1:0] tag_mem [SETS];
	logic [WAYS-1:0]         valid_q [SETS];
	logic [LFSR_W-1:0]       lfsr_q;

	// combinational
	logic [LA-1:0]     line_in;
	logic [PW-1:0]     sprod;
	logic [LA-1:0]     set_rem;
	logic [SW-1:0]     set_s1;
	logic [VPW-1:0]    vprod;
	logic [LFSR_W-1:0] vq;
	logic [LFSR_W-1:0] vrem;
	logic [WW-1:0]     victim;
	logic [LFSR_W-1:0] lfsr_next;

	logic [WAYS-1:0][LA-1:0] tag_row;
	lookup_t                 look;
	logic [WW-1:0]           sel_way;
	logic [WW+1:0]           way_ext;
	logic                    tag_we;
	logic                    any_valid;

	assign cfg_ready = 1'b1;

	assign out_en   = !out_valid || !out_stall;
	assign commit   = v_s2 && out_en;
	assign s1_move  = v_s1 && (!v_s2 || out_en);
	assign in_stall = v_s1 && !s1_move;
	assign accept   = in_valid && !in_stall;

	assign line_in = address[EA-1:SHIFT];
	assign sprod   = PW'(line_in) * PW'(SRECIP);

	// q * SETS never exceeds the line, so LA-bit wrap is exact
	assign set_rem = line_s1 - (q_s1 * SETS_T);
	assign set_s1  = SW'(set_rem);

	assign vprod  = VPW'(lfsr_q) * VPW'(VRECIP);
	assign vq     = vprod[VK +: LFSR_W];
	assign vrem   = lfsr_q - (vq * WAYS_T);
	assign victim = WW'(vrem);

	assign lfsr_next = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (s1_move) begin
				v_s1 <= 1'b0;
			end
			if (s1_move) begin
				v_s2 <= 1'b1;
			end else if (out_en) begin
				v_s2 <= 1'b0;
			end
			if (out_en) begin
				out_valid <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			line_s1 <= line_in;
			q_s1    <= sprod[SK +: LA];
		end
	end

	// forward the row write of the item leaving s2 to the item entering it
	always_ff @(posedge clk) begin
		if (s1_move) begin
			mode_s2    <= mode_s1;
			line_s2    <= line_s1;
			set_s2     <= set_s1;
			byp_s2     <= tag_we && (set_s2 == set_s1);
			byp_way_s2 <= sel_way;
			byp_tag_s2 <= line_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[set_s2][sel_way] <= line_s2;
		end
		if (s1_move) begin
			tag_rd_s2 <= tag_mem[set_s1];
		end
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			if (byp_s2 && (byp_way_s2 == WW'(w))) begin
				tag_row[w] = byp_tag_s2;
			end else begin
				tag_row[w] = tag_rd_s2[w];
			end
		end
	end

	satl_way_sel #(
		.WAYS  (WAYS),
		.TAG_W (LA),
		.WAY_W (WW)
	) u_way_sel (
		.valid_row (valid_q[set_s2]),
		.tag_row   (tag_row),
		.line      (line_s2),
		.victim    (victim),
		.flags     (look),
		.sel_way   (sel_way)
	);

	assign tag_we  = commit && (mode_s2 == MODE_READ) && !look.hit;
	assign way_ext = {2'b00, sel_way};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) begin
				valid_q[s] <= '0;
			end
		end else if (commit) begin
			if (mode_s2 == MODE_INVAL) begin
				for (int s = 0; s < SETS; s++) begin
					valid_q[s] <= '0;
				end
			end else if (!look.hit) begin
				valid_q[set_s2][sel_way] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= LFSR_ONE;
		end else if (cfg_valid) begin
			lfsr_q <= (cfg_data == '0) ? LFSR_ONE : cfg_data;
		end else if (tag_we && look.evicted) begin
			lfsr_q <= lfsr_next;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (mode_s2 == MODE_INVAL) begin
				hit     <= 1'b0;
				way     <= '0;
				filled  <= 1'b0;
				evicted <= 1'b0;
			end else begin
				hit     <= look.hit;
				way     <= way_ext[WAY_OUT_W-1:0];
				filled  <= look.filled;
				evicted <= look.evicted;
			end
		end
	end

	always_comb begin
		any_valid = 1'b0;
		for (int s = 0; s < SETS; s++) begin
			any_valid = any_valid | (|valid_q[s]);
		end
	end

	a_evict_is_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && evicted |-> filled && !hit)
		else $error("eviction reported without a fill");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> !in_stall)
		else $error("input stalled with an empty first stage");

	a_inval_clears: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (mode_s2 == MODE_INVAL) |=> !any_valid)
		else $error("valid bits left set after invalidate");

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("replacement lfsr reached zero");

endmodule

// ----- verif/satl_lookup_checker.sv -----
`timescale 1ns / 1ps
// checker of the set-associative tag lookup: watches the seed, access and result channels,
// keeps its own copy of the tag store and replacement lfsr and compares every result item
// depends on satl_pkg
module satl_lookup_checker #(
	parameter int LINE_BYTES = 64,
	parameter int SETS       = 64,
	parameter int WAYS       = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [satl_pkg::LFSR_W-1:0]         cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                mode,
	input  logic [satl_pkg::ADDR_W-1:0]         address,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic                                hit,
	input  logic [satl_pkg::WAY_OUT_W-1:0]      way,
	input  logic                                filled,
	input  logic                                evicted,
	output int                                  mismatch_count,
	output int                                  lookups_pending
);
	import satl_pkg::*;

	localparam int LINE_SHIFT = $clog2(LINE_BYTES);
	localparam int LINE_W     = ADDR_W - LINE_SHIFT;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic                 hit;
		logic [WAY_OUT_W-1:0] way;
		logic                 filled;
		logic                 evicted;
	} lookup_result_t;

	logic              line_present [SETS*WAYS];
	logic [LINE_W-1:0] line_addr_held [SETS*WAYS];
	logic [LFSR_W-1:0] victim_lfsr = LFSR_ONE;

	lookup_result_t expected_lookups [$];
	int             bad_results = 0;

	initial begin
		mismatch_count = 0;
		lookups_pending = 0;
		foreach (line_present[i]) line_present[i] = 1'b0;
	end

	// walks the set like the cache does and updates the store copy
	function automatic lookup_result_t predict_lookup(logic op, logic [ADDR_W-1:0] addr);
		lookup_result_t    res;
		logic [LINE_W-1:0] line;
		int                base;
		int                w;
		int                victim;
		logic              lsb;
		res = '0;
		if (op == MODE_INVAL) begin
			foreach (line_present[i]) line_present[i] = 1'b0;
			return res;
		end
		line = addr[ADDR_W-1:LINE_SHIFT];
		base = int'(line % SETS) * WAYS;
		for (w = 0; w < WAYS; w++) begin
			if (line_present[base+w] && line_addr_held[base+w] == line) begin
				res.hit = 1'b1;
				res.way = w[WAY_OUT_W-1:0];
				return res;
			end
		end
		for (w = 0; w < WAYS; w++) begin
			if (!line_present[base+w]) begin
				line_present[base+w] = 1'b1;
				line_addr_held[base+w] = line;
				res.way = w[WAY_OUT_W-1:0];
				res.filled = 1'b1;
				return res;
			end
		end
		// set is full: lfsr picks the victim, then steps once
		victim = int'(victim_lfsr % WAYS);
		lsb = victim_lfsr[0];
		victim_lfsr = victim_lfsr >> 1;
		if (lsb)
			victim_lfsr = victim_lfsr ^ LFSR_TAPS;
		line_addr_held[base+victim] = line;
		res.way = victim[WAY_OUT_W-1:0];
		res.filled = 1'b1;
		res.evicted = 1'b1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_result_t exp_res;
		lookup_result_t got_res;
		if (!arst_n) begin
			foreach (line_present[i]) line_present[i] = 1'b0;
			victim_lfsr = LFSR_ONE;
			expected_lookups.delete();
			lookups_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				victim_lfsr = (cfg_data == '0) ? LFSR_ONE : cfg_data;
			if (in_valid && !in_stall)
				expected_lookups.push_back(predict_lookup(mode, address));
			if (out_valid && !out_stall) begin
				got_res = '{hit: hit, way: way, filled: filled, evicted: evicted};
				if (expected_lookups.size() == 0) begin
					bad_results++;
					if (bad_results <= REPORT_MAX)
						$display("%0t: result item with nothing pending: %s",
							$realtime,
							$sformatf("hit=%0b way=%0d filled=%0b evicted=%0b",
								hit, way, filled, evicted));
				end else begin
					exp_res = expected_lookups.pop_front();
					if (got_res !== exp_res) begin
						bad_results++;
						if (bad_results <= REPORT_MAX)
							$display("%0t: lookup mismatch: expected %s, got %s",
								$realtime,
								$sformatf("hit=%0b way=%0d filled=%0b evicted=%0b",
									exp_res.hit, exp_res.way, exp_res.filled,
									exp_res.evicted),
								$sformatf("hit=%0b way=%0d filled=%0b evicted=%0b",
									hit, way, filled, evicted));
					end
				end
			end
			lookups_pending <= expected_lookups.size();
		end
		mismatch_count <= bad_results;
	end

endmodule

// ----- verif/set_assoc_cache_tag_lookup_tb.sv -----
`timescale 1ns / 1ps
// testbench top of the set-associative tag lookup: clock, reset, seed writes and access items
// depends on satl_pkg, set_assoc_cache_tag_lookup and satl_lookup_checker
module set_assoc_cache_tag_lookup_tb;
	import satl_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 64;
	localparam int DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [LFSR_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 mode = MODE_READ;
	logic [ADDR_W-1:0]    address = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 hit;
	logic [WAY_OUT_W-1:0] way;
	logic                 filled;
	logic                 evicted;

	int mismatch_count;
	int lookups_pending;

	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   hold_cnt = 0;
	int   cycle_cnt = 0;

	// few tags over few sets so sets fill up and evict
	logic [19:0] hot_tags [8];
	logic [5:0]  hot_sets [4];

	set_assoc_cache_tag_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.address   (address),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.way       (way),
		.filled    (filled),
		.evicted   (evicted)
	);

	satl_lookup_checker u_lookup_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.address         (address),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.hit             (hit),
		.way             (way),
		.filled          (filled),
		.evicted         (evicted),
		.mismatch_count  (mismatch_count),
		.lookups_pending (lookups_pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("set_assoc_cache_tag_lookup_tb failed");
			$finish;
		end
	end

	// result side: random stall, plus one long hold-off when requested
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			out_stall <= 1'b1;
			if (hold_cnt == LONG_HOLD - 1)
				hold_done <= 1'b1;
			hold_cnt <= hold_cnt + 1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	task automatic write_seed(input logic [LFSR_W-1:0] seed);
		cfg_valid <= 1'b1;
		cfg_data <= seed;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic push_item(input logic op, input logic [ADDR_W-1:0] addr);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			mode <= 1'($urandom);
			address <= $urandom;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		address <= addr;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (lookups_pending != 0);
	endtask

	task automatic run_phase(input logic [LFSR_W-1:0] seed, input int n_items, input int tx_pct,
	                         input int rx_pct, input bit with_hold);
		int         k;
		int         r;
		logic [5:0] set_sel;
		write_seed(seed);
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
		foreach (hot_tags[i]) hot_tags[i] = 20'($urandom);
		foreach (hot_sets[i]) hot_sets[i] = 6'($urandom);
		for (k = 0; k < n_items; k++) begin
			if (with_hold && k == 20)
				hold_req <= 1'b1;
			if (!with_hold && k == n_items / 2)
				wait_all_results();
			r = $urandom_range(99);
			if (r < 3) begin
				push_item(MODE_INVAL, $urandom);
			end else if (r < 13) begin
				push_item(MODE_READ, $urandom);
			end else begin
				set_sel = ($urandom_range(9) < 7) ? hot_sets[$urandom_range(3)] : 6'($urandom);
				push_item(MODE_READ, {hot_tags[$urandom_range(7)], set_sel, 6'($urandom)});
			end
		end
		wait_all_results();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero seed loads as one; fills, hits, evictions, invalidates, address extremes
		write_seed('0);
		push_item(MODE_READ, 32'h0000_0000);
		push_item(MODE_READ, 32'h0000_003F);
		push_item(MODE_READ, 32'hFFFF_FFFF);
		push_item(MODE_READ, 32'hFFFF_FFC0);
		push_item(MODE_READ, 32'h0000_1000);
		push_item(MODE_READ, 32'h0000_2000);
		push_item(MODE_READ, 32'h0000_3000);
		push_item(MODE_READ, 32'h0000_4000);
		push_item(MODE_READ, 32'h0000_5000);
		push_item(MODE_READ, 32'h0000_6000);
		push_item(MODE_READ, 32'h0000_1000);
		push_item(MODE_READ, 32'h8000_0000);
		push_item(MODE_READ, 32'h7FFF_FFC0);
		push_item(MODE_INVAL, 32'hFFFF_FFFF);
		push_item(MODE_READ, 32'h0000_0000);
		push_item(MODE_READ, 32'hFFFF_FFFF);
		push_item(MODE_INVAL, 32'h0000_0000);
		push_item(MODE_INVAL, 32'h0000_0000);
		push_item(MODE_READ, 32'h0000_0040);
		push_item(MODE_READ, 32'h0000_0040);
		push_item(MODE_READ, 32'h0000_1040);
		push_item(MODE_READ, 32'hAAAA_AAAA);
		push_item(MODE_READ, 32'h5555_5555);
		wait_all_results();

		run_phase(16'hFFFF, 135, 28, 85, 1'b0);
		run_phase(16'($urandom_range(2, 65534)), 135, 85, 28, 1'b0);
		run_phase(16'h0001, 130, 0, 0, 1'b1);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && lookups_pending == 0)
			$display("set_assoc_cache_tag_lookup_tb passed");
		else
			$display("set_assoc_cache_tag_lookup_tb failed");
		$finish;
	end

endmodule
